>>> rtl/core/pi_or_two_point_controller_defines.svh
// Assertion macros for the percent drive controller.
// Used by files that check their own logic; depends on clk_i and rst_ni in scope.
`ifndef PI_OR_TWO_POINT_CONTROLLER_DEFINES_SVH
`define PI_OR_TWO_POINT_CONTROLLER_DEFINES_SVH

// property must hold at every edge outside reset
`define PITPC_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// same-cycle implication
`define PITPC_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define PITPC_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/core/pitpc_pkg.sv
// Shared types and constants of the percent drive controller.
// Holds the microcode ROM, opcodes and divider control structs; no dependencies.
package pitpc_pkg;

  localparam int DIV_W  = 48;  // dividend / quotient width of the shared divider
  localparam int DVS_W  = 16;  // divisor width
  localparam int ITER_W = 6;   // iteration count width

  localparam logic [ITER_W-1:0] ITER_KP    = 6'd8;
  localparam logic [ITER_W-1:0] ITER_INTEG = 6'd48;
  localparam logic [ITER_W-1:0] ITER_BACK  = 6'd40;

  localparam logic [1:0] REG_MODE       = 2'd0;
  localparam logic [1:0] REG_BAND       = 2'd1;
  localparam logic [1:0] REG_RESET_TIME = 2'd2;

  localparam logic [14:0] RST_BAND       = 15'd100;
  localparam logic [14:0] RST_RESET_TIME = 15'd60;

  localparam int PC_W = 5;

  typedef enum logic [4:0] {
    OP_LOAD,
    OP_BR_MODE,
    OP_DIV_KP,
    OP_WAIT_KP,
    OP_MUL_EK,
    OP_MUL_ESKP,
    OP_MUL_TK,
    OP_MUL_KT,
    OP_DIV_INTEG,
    OP_WAIT_INTEG,
    OP_SUM,
    OP_BR_CLAMP,
    OP_MUL_BACK,
    OP_DIV_BACK,
    OP_WAIT_BACK,
    OP_PI_DONE,
    OP_TWO_POINT
  } op_e;

  localparam logic [PC_W-1:0] PC_LOAD      = 5'd0;
  localparam logic [PC_W-1:0] PC_BR_MODE   = 5'd1;
  localparam logic [PC_W-1:0] PC_SUM       = 5'd10;
  localparam logic [PC_W-1:0] PC_PI_DONE   = 5'd15;
  localparam logic [PC_W-1:0] PC_TWO_POINT = 5'd16;

  typedef struct packed {
    op_e             op;
    logic [PC_W-1:0] tgt;  // jump target when the op branches
  } uword_t;

  typedef struct packed {
    logic              start;
    logic [ITER_W-1:0] iters;
  } div_ctl_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_sts_t;

  // Microcode ROM
  function automatic uword_t ucode(input logic [PC_W-1:0] pc);
    uword_t w;
    case (pc)
      5'd0:    w = '{OP_LOAD,       PC_BR_MODE};
      5'd1:    w = '{OP_BR_MODE,    PC_TWO_POINT};
      5'd2:    w = '{OP_DIV_KP,     PC_LOAD};
      5'd3:    w = '{OP_WAIT_KP,    PC_LOAD};
      5'd4:    w = '{OP_MUL_EK,     PC_LOAD};
      5'd5:    w = '{OP_MUL_ESKP,   PC_LOAD};
      5'd6:    w = '{OP_MUL_TK,     PC_LOAD};
      5'd7:    w = '{OP_MUL_KT,     PC_LOAD};
      5'd8:    w = '{OP_DIV_INTEG,  PC_SUM};
      5'd9:    w = '{OP_WAIT_INTEG, PC_LOAD};
      5'd10:   w = '{OP_SUM,        PC_LOAD};
      5'd11:   w = '{OP_BR_CLAMP,   PC_PI_DONE};
      5'd12:   w = '{OP_MUL_BACK,   PC_LOAD};
      5'd13:   w = '{OP_DIV_BACK,   PC_PI_DONE};
      5'd14:   w = '{OP_WAIT_BACK,  PC_LOAD};
      5'd15:   w = '{OP_PI_DONE,    PC_LOAD};
      5'd16:   w = '{OP_TWO_POINT,  PC_LOAD};
      default: w = '{OP_PI_DONE,    PC_LOAD};
    endcase
    return w;
  endfunction

endpackage

>>> rtl/core/pitpc_div.sv
// Shared restoring divider, one quotient bit per cycle, unsigned operands.
// Depends on pitpc_pkg for widths and the control/status structs.
module pitpc_div (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  pitpc_pkg::div_ctl_t           ctl_i,
  input  logic [pitpc_pkg::DIV_W-1:0]   dividend_i,
  input  logic [pitpc_pkg::DVS_W-1:0]   divisor_i,
  output pitpc_pkg::div_sts_t           sts_o,
  output logic [pitpc_pkg::DIV_W-1:0]   quotient_o
);

  logic [pitpc_pkg::DIV_W-1:0]  quo_q;
  logic [pitpc_pkg::DVS_W-1:0]  rem_q;
  logic [pitpc_pkg::DVS_W-1:0]  dvs_q;
  logic [pitpc_pkg::ITER_W-1:0] cnt_q;
  logic                         busy_q;
  logic                         done_q;

  logic [pitpc_pkg::ITER_W-1:0] shamt;
  logic [pitpc_pkg::DVS_W:0]    shifted;
  logic [pitpc_pkg::DVS_W:0]    trial;
  logic                         fit;

  // dividend is known to fit in iters bits; park it at the top
  assign shamt   = pitpc_pkg::ITER_W'(pitpc_pkg::DIV_W) - ctl_i.iters;
  assign shifted = {rem_q, quo_q[pitpc_pkg::DIV_W-1]};
  assign trial   = shifted - {1'b0, dvs_q};
  assign fit     = !trial[pitpc_pkg::DVS_W];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else if (ctl_i.start) begin
      busy_q <= 1'b1;
      done_q <= 1'b0;
      cnt_q  <= ctl_i.iters;
    end else if (busy_q) begin
      cnt_q <= cnt_q - 1'b1;
      if (cnt_q == pitpc_pkg::ITER_W'(1)) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end
    end else begin
      done_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.start) begin
      quo_q <= dividend_i << shamt;
      rem_q <= '0;
      dvs_q <= divisor_i;
    end else if (busy_q) begin
      quo_q <= {quo_q[pitpc_pkg::DIV_W-2:0], fit};
      rem_q <= fit ? trial[pitpc_pkg::DVS_W-1:0] : shifted[pitpc_pkg::DVS_W-1:0];
    end
  end

  assign sts_o      = '{busy: busy_q, done: done_q};
  assign quotient_o = quo_q;

endmodule

>>> rtl/core/pi_or_two_point_controller.sv
// Percent drive controller: PI law with anti-windup or two-point law.
// Microcoded sequencer over a small datapath; uses pitpc_pkg, pitpc_div and the defines header.
//
//  channel   | dir | payload                                   | transaction
//  s_axis    | in  | tdata: setpoint, actual, interval         | tvalid & tready
//  m_axis    | out | tdata: drive; tuser: hold                 | tvalid & tready
//  cfg       | in  | cfg_idx_i, cfg_data_i (mode/band/reset_t) | cfg_we_i
//
// A PI transaction waits on the shared divider, one quotient bit per cycle (8 bits for the
// gain, 48 for the integral term, 40 for back-calc when the drive clamps at 100 and the sum
// is back-computed).
// Reset returns to the input wait step with an empty output register and cleared state.
// A stalled output register holds the finish step; a new input is taken once the
// previous result is loaded, even while it still waits on m_axis_tready.
`include "pi_or_two_point_controller_defines.svh"

module pi_or_two_point_controller (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [39:0] s_axis_tdata,   // [15:0] setpoint, [31:16] actual, [39:32] interval
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [7:0]  m_axis_tdata,   // [6:0] drive, [7] zero
  output logic        m_axis_tuser,   // [0] hold
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [14:0] cfg_data_i
);

  // configuration
  logic        mode_q;
  logic [14:0] band_q;
  logic [14:0] rt_q;

  // sequencer
  logic [pitpc_pkg::PC_W-1:0] pc_q, pc_d;
  pitpc_pkg::uword_t          uw;

  // state
  logic signed [31:0] es_q;
  logic [6:0]         last_drive_q;

  // datapath
  logic signed [15:0] sp_q;
  logic signed [15:0] act_q;
  logic [7:0]         tk_q;
  logic signed [16:0] e_q;
  logic [7:0]         kp_q;
  logic signed [25:0] ek_q;
  logic signed [47:0] t_q;
  logic [15:0]        kt_q;
  logic signed [47:0] integ_q;
  logic signed [48:0] d_q;
  logic               neg_q;

  // output register
  logic               out_valid_q;
  logic [6:0]         out_drive_q;
  logic               out_hold_q;

  logic in_acc, out_free, finish;

  // divider
  pitpc_pkg::div_ctl_t            div_ctl;
  pitpc_pkg::div_sts_t            div_sts;
  logic [pitpc_pkg::DIV_W-1:0]    div_dividend;
  logic [pitpc_pkg::DVS_W-1:0]    div_divisor;
  logic [pitpc_pkg::DIV_W-1:0]    quo;
  logic [pitpc_pkg::DIV_W-1:0]    t_abs;

  // arithmetic
  logic signed [16:0] e_w;
  logic signed [32:0] es_sum;
  logic signed [31:0] es_sat;
  logic signed [8:0]  kp9;
  logic signed [8:0]  tk9;
  logic signed [25:0] mul_ek;
  logic signed [40:0] mul_eskp;
  logic signed [56:0] mul_tk;
  logic [15:0]        mul_kt;
  logic signed [26:0] x_w;
  logic signed [15:0] rt16;
  logic signed [42:0] mul_back;
  logic signed [48:0] sum_d;
  logic signed [31:0] back_sat;
  logic [14:0]        band_nz;
  logic               rt_zero, kt_zero, d_over;
  logic [6:0]         pi_drive;
  logic               pi_clear;
  logic signed [16:0] sp17, act17, half17, lo17, hi17;
  logic [6:0]         tp_drive;
  logic               tp_hold;

  assign uw = pitpc_pkg::ucode(pc_q);

  assign s_axis_tready = (uw.op == pitpc_pkg::OP_LOAD);
  assign in_acc        = s_axis_tvalid && s_axis_tready;
  assign out_free      = !out_valid_q || m_axis_tready;
  assign finish        = ((uw.op == pitpc_pkg::OP_PI_DONE) ||
                          (uw.op == pitpc_pkg::OP_TWO_POINT)) && out_free;

  assign rt_zero = (rt_q == 15'd0);
  assign kt_zero = (kt_q == 16'd0);
  assign d_over  = (d_q > 49'sd100);
  assign band_nz = (band_q == 15'd0) ? 15'd1 : band_q;

  assign e_w    = {sp_q[15], sp_q} - {act_q[15], act_q};
  assign es_sum = {es_q[31], es_q} + {{16{e_w[16]}}, e_w};
  assign es_sat = (es_sum[32] != es_sum[31]) ?
                  (es_sum[32] ? 32'sh8000_0000 : 32'sh7FFF_FFFF) : es_sum[31:0];

  assign kp9      = {1'b0, kp_q};
  assign tk9      = {1'b0, tk_q};
  assign rt16     = {1'b0, rt_q};
  assign mul_ek   = e_q * kp9;
  assign mul_eskp = es_q * kp9;
  assign mul_tk   = t_q * tk9;
  assign mul_kt   = kp_q * tk_q;
  assign x_w      = $signed({20'd0, last_drive_q}) - {ek_q[25], ek_q};
  assign mul_back = x_w * rt16;
  assign sum_d    = {{23{ek_q[25]}}, ek_q} + {integ_q[47], integ_q};

  assign t_abs = t_q[47] ? 48'(-t_q) : t_q;

  // back-computed sum, truncated toward zero, saturated to 32 bits
  always_comb begin
    if (!neg_q) begin
      back_sat = (quo > 48'h0000_7FFF_FFFF) ? 32'sh7FFF_FFFF : quo[31:0];
    end else begin
      back_sat = (quo > 48'h0000_8000_0000) ? 32'sh8000_0000 : -$signed(quo[31:0]);
    end
  end

  assign pi_clear = d_q[48] || es_q[31];
  assign pi_drive = d_q[48] ? 7'd0 : d_q[6:0];

  // two-point comparison
  assign sp17   = {sp_q[15], sp_q};
  assign act17  = {act_q[15], act_q};
  assign half17 = {3'b000, band_q[14:1]};
  assign lo17   = sp17 - half17;
  assign hi17   = sp17 + half17;
  always_comb begin
    tp_drive = 7'd0;
    tp_hold  = 1'b0;
    if (act17 < lo17) begin
      tp_drive = 7'd0;
    end else if (act17 > hi17) begin
      tp_drive = 7'd100;
    end else begin
      tp_hold = 1'b1;
    end
  end

  // divider requests
  always_comb begin
    div_ctl      = '{start: 1'b0, iters: pitpc_pkg::ITER_KP};
    div_dividend = 48'd200;
    div_divisor  = {1'b0, band_nz};
    case (uw.op)
      pitpc_pkg::OP_DIV_KP: begin
        div_ctl.start = 1'b1;
      end
      pitpc_pkg::OP_DIV_INTEG: begin
        div_ctl      = '{start: !rt_zero, iters: pitpc_pkg::ITER_INTEG};
        div_dividend = t_abs;
        div_divisor  = {1'b0, rt_q};
      end
      pitpc_pkg::OP_DIV_BACK: begin
        div_ctl      = '{start: !kt_zero, iters: pitpc_pkg::ITER_BACK};
        div_dividend = t_abs;
        div_divisor  = kt_q;
      end
      default: begin
      end
    endcase
  end

  pitpc_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .ctl_i      (div_ctl),
    .dividend_i (div_dividend),
    .divisor_i  (div_divisor),
    .sts_o      (div_sts),
    .quotient_o (quo)
  );

  // step counter with conditional jumps
  always_comb begin
    case (uw.op)
      pitpc_pkg::OP_LOAD:       pc_d = in_acc ? uw.tgt : pc_q;
      pitpc_pkg::OP_BR_MODE:    pc_d = mode_q ? uw.tgt : pc_q + 1'b1;
      pitpc_pkg::OP_WAIT_KP,
      pitpc_pkg::OP_WAIT_INTEG,
      pitpc_pkg::OP_WAIT_BACK:  pc_d = div_sts.done ? pc_q + 1'b1 : pc_q;
      pitpc_pkg::OP_DIV_INTEG:  pc_d = rt_zero ? uw.tgt : pc_q + 1'b1;
      pitpc_pkg::OP_BR_CLAMP:   pc_d = d_over ? pc_q + 1'b1 : uw.tgt;
      pitpc_pkg::OP_DIV_BACK:   pc_d = kt_zero ? uw.tgt : pc_q + 1'b1;
      pitpc_pkg::OP_PI_DONE,
      pitpc_pkg::OP_TWO_POINT:  pc_d = out_free ? uw.tgt : pc_q;
      default:                  pc_d = pc_q + 1'b1;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q         <= pitpc_pkg::PC_LOAD;
      mode_q       <= 1'b0;
      band_q       <= pitpc_pkg::RST_BAND;
      rt_q         <= pitpc_pkg::RST_RESET_TIME;
      es_q         <= '0;
      last_drive_q <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      pc_q <= pc_d;
      if (cfg_we_i) begin
        case (cfg_idx_i)
          pitpc_pkg::REG_MODE:       mode_q <= cfg_data_i[0];
          pitpc_pkg::REG_BAND:       band_q <= cfg_data_i;
          pitpc_pkg::REG_RESET_TIME: rt_q   <= cfg_data_i;
          default: begin
          end
        endcase
      end
      case (uw.op)
        pitpc_pkg::OP_BR_MODE: begin
          if (!mode_q) es_q <= es_sat;
        end
        pitpc_pkg::OP_DIV_BACK: begin
          if (kt_zero) es_q <= '0;
        end
        pitpc_pkg::OP_WAIT_BACK: begin
          if (div_sts.done) es_q <= back_sat;
        end
        pitpc_pkg::OP_PI_DONE: begin
          if (out_free) begin
            if (pi_clear) es_q <= '0;
            last_drive_q <= pi_drive;
          end
        end
        default: begin
        end
      endcase
      if (finish) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    case (uw.op)
      pitpc_pkg::OP_LOAD: begin
        if (in_acc) begin
          sp_q  <= s_axis_tdata[15:0];
          act_q <= s_axis_tdata[31:16];
          tk_q  <= s_axis_tdata[39:32];
        end
      end
      pitpc_pkg::OP_BR_MODE:   e_q  <= e_w;
      pitpc_pkg::OP_WAIT_KP:   kp_q <= quo[7:0];
      pitpc_pkg::OP_MUL_EK:    ek_q <= mul_ek;
      pitpc_pkg::OP_MUL_ESKP:  t_q  <= {{7{mul_eskp[40]}}, mul_eskp};
      pitpc_pkg::OP_MUL_TK:    t_q  <= mul_tk[47:0];
      pitpc_pkg::OP_MUL_KT:    kt_q <= mul_kt;
      pitpc_pkg::OP_DIV_INTEG: begin
        neg_q <= t_q[47];
        if (rt_zero) integ_q <= '0;
      end
      pitpc_pkg::OP_WAIT_INTEG: begin
        integ_q <= neg_q ? -$signed(quo) : $signed(quo);
      end
      pitpc_pkg::OP_SUM:       d_q <= sum_d;
      pitpc_pkg::OP_MUL_BACK:  t_q <= {{5{mul_back[42]}}, mul_back};
      pitpc_pkg::OP_DIV_BACK: begin
        neg_q <= t_q[47];
        d_q   <= 49'sd100;
      end
      pitpc_pkg::OP_PI_DONE: begin
        if (out_free) begin
          out_drive_q <= pi_drive;
          out_hold_q  <= 1'b0;
        end
      end
      pitpc_pkg::OP_TWO_POINT: begin
        if (out_free) begin
          out_drive_q <= tp_drive;
          out_hold_q  <= tp_hold;
        end
      end
      default: begin
      end
    endcase
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {1'b0, out_drive_q};
  assign m_axis_tuser  = out_hold_q;

  `PITPC_ASSERT_ALWAYS(a_last_drive_range, last_drive_q <= 7'd100, "stored drive above 100")
  `PITPC_ASSERT_IMP(a_hold_zero_drive, m_axis_tvalid && m_axis_tuser, m_axis_tdata[6:0] == 7'd0, "hold with nonzero drive")
  `PITPC_ASSERT_NXT(a_one_at_a_time, in_acc, !s_axis_tready, "input taken while busy")
  `PITPC_ASSERT_IMP(a_div_done_waited, div_sts.done, (uw.op == pitpc_pkg::OP_WAIT_KP) || (uw.op == pitpc_pkg::OP_WAIT_INTEG) || (uw.op == pitpc_pkg::OP_WAIT_BACK), "divider result not consumed")

endmodule
